// ===== design/dmd_pkg.sv =====
// shared types and constants of the decimal multiply/divide unit
package dmd_pkg;

	localparam int unsigned MAG_W  = 128;
	localparam int unsigned PROD_W = 256;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NULL    = 2'd1;
	localparam status_t ST_DIVZERO = 2'd2;
	localparam status_t ST_NONTERM = 2'd3;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PRECISION = 1'd0;
	localparam cfg_idx_t CFG_SCALE     = 1'd1;

	localparam logic [5:0] PRECISION_RST = 6'd38;
	localparam logic [5:0] SCALE_RST     = 6'd0;

	typedef struct packed {
		logic               mode;
		logic signed [63:0] left_upper;
		logic [63:0]        left_lower;
		logic signed [63:0] right_upper;
		logic [63:0]        right_lower;
	} operand_t;

	typedef struct packed {
		logic signed [63:0] result_upper;
		logic [63:0]        result_lower;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

// ===== design/decimal_multiply_divide_half_up.sv =====
// top level: sequencer, serial units and registers of the decimal multiply/divide unit
// one item at a time; input stalled from transfer until the result is registered
// multiply: scale power of ten, serial multiply, serial divide, rounding, precision limit
// divide: first strips trailing zero bits (up to 127) and factors of five (up to 54)
//   from the divisor, one divide-by-five pass each; a zero divisor skips to the output
// asynchronous reset: idle, no result held, precision 38, scale 0
module decimal_multiply_divide_half_up #(
	parameter int unsigned MAX_PRECISION = 38
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operand_valid,
	output logic               operand_stall,
	input  dmd_pkg::operand_t  operand,
	output logic               result_valid,
	input  logic               result_stall,
	output dmd_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  dmd_pkg::cfg_idx_t  cfg_index,
	input  logic [5:0]         cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_STRIP2, S_STRIP5, S_TERM, S_POW, S_MUL, S_DIV, S_ROUND, S_LIM, S_OUT
	} state_t;

	state_t                      state_q;
	logic [5:0]                  precision_q;
	logic [5:0]                  scale_q;
	logic [5:0]                  prec_eff;
	logic [5:0]                  sc_eff;
	logic [5:0]                  prec_s1_q;
	logic [5:0]                  cnt_q;
	logic                        mode_q;
	logic                        neg_q;
	logic [dmd_pkg::MAG_W-1:0]   ma_q;
	logic [dmd_pkg::MAG_W-1:0]   mb_q;
	logic [dmd_pkg::MAG_W-1:0]   c_q;
	logic [dmd_pkg::MAG_W-1:0]   p_q;
	logic [dmd_pkg::MAG_W-1:0]   den_q;
	logic [dmd_pkg::PROD_W-1:0]  q_q;
	logic                        res_valid_q;
	dmd_pkg::result_t            res_q;
	dmd_pkg::result_t            res_next_q;
	dmd_pkg::unit_ctl_t          mul_ctl;
	dmd_pkg::unit_ctl_t          div_ctl;
	dmd_pkg::unit_ctl_t          d5_ctl;
	logic                        mul_start_q;
	logic                        div_start_q;
	logic                        d5_start_q;
	logic [dmd_pkg::PROD_W-1:0]  mul_prod;
	logic [dmd_pkg::PROD_W-1:0]  div_q;
	logic [dmd_pkg::MAG_W-1:0]   div_r;
	logic [dmd_pkg::PROD_W-1:0]  div_n;
	logic [dmd_pkg::MAG_W-1:0]   div_d;
	logic                        d5_exact;
	logic [dmd_pkg::MAG_W-1:0]   d5_quot;
	logic [dmd_pkg::MAG_W-1:0]   left_v;
	logic [dmd_pkg::MAG_W-1:0]   right_v;
	logic [dmd_pkg::MAG_W-1:0]   ma_in;
	logic [dmd_pkg::MAG_W-1:0]   mb_in;
	logic [dmd_pkg::MAG_W-1:0]   q_low;
	logic                        accept;

	assign prec_eff = (precision_q > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : precision_q;
	assign sc_eff   = (scale_q > prec_eff) ? prec_eff : scale_q;

	assign left_v  = {operand.left_upper, operand.left_lower};
	assign right_v = {operand.right_upper, operand.right_lower};
	assign ma_in   = operand.left_upper[63] ? (~left_v + 128'd1) : left_v;
	assign mb_in   = operand.right_upper[63] ? (~right_v + 128'd1) : right_v;

	assign operand_stall = (state_q != S_IDLE);
	assign accept        = operand_valid && !operand_stall;
	assign cfg_ready     = 1'b1;

	assign mul_ctl.start = mul_start_q;
	assign div_ctl.start = div_start_q;
	assign d5_ctl.start  = d5_start_q;

	assign div_n = (state_q == S_TERM) ? {{dmd_pkg::MAG_W{1'b0}}, ma_q} : mul_prod;
	assign div_d = (state_q == S_TERM) ? c_q : den_q;

	assign q_low = neg_q ? (~q_q[dmd_pkg::MAG_W-1:0] + 128'd1) : q_q[dmd_pkg::MAG_W-1:0];

	dmd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_ctl.start),
		.x      (ma_q),
		.y      (mode_q ? p_q : mb_q),
		.done   (mul_ctl.done),
		.prod   (mul_prod)
	);

	dmd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_ctl.start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_ctl.done),
		.q      (div_q),
		.r      (div_r)
	);

	dmd_div5 u_div5 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (d5_ctl.start),
		.c      (c_q),
		.done   (d5_ctl.done),
		.exact  (d5_exact),
		.quot   (d5_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= dmd_pkg::PRECISION_RST;
			scale_q     <= dmd_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dmd_pkg::CFG_PRECISION: precision_q <= cfg_data;
				dmd_pkg::CFG_SCALE:     scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			d5_start_q  <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			d5_start_q  <= 1'b0;
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= operand.mode;
						neg_q     <= operand.left_upper[63] ^ operand.right_upper[63];
						ma_q      <= ma_in;
						mb_q      <= mb_in;
						c_q       <= mb_in;
						prec_s1_q <= prec_eff;
						cnt_q     <= sc_eff;
						p_q       <= 128'd1;
						if (!operand.mode) begin
							state_q <= S_POW;
						end else if (mb_in == '0) begin
							res_next_q <= '{result_upper: '0, result_lower: '0,
								status: dmd_pkg::ST_DIVZERO};
							state_q <= S_OUT;
						end else begin
							state_q <= S_STRIP2;
						end
					end
				end
				S_STRIP2: begin
					if (!c_q[0]) begin
						c_q <= {1'b0, c_q[dmd_pkg::MAG_W-1:1]};
					end else begin
						d5_start_q <= 1'b1;
						state_q    <= S_STRIP5;
					end
				end
				S_STRIP5: begin
					if (d5_ctl.done) begin
						if (d5_exact) begin
							c_q        <= d5_quot;
							d5_start_q <= 1'b1;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_TERM;
						end
					end
				end
				S_TERM: begin
					if (div_ctl.done) begin
						if (div_r != '0) begin
							res_next_q <= '{result_upper: '0, result_lower: '0,
								status: dmd_pkg::ST_NONTERM};
							state_q <= S_OUT;
						end else begin
							state_q <= S_POW;
						end
					end
				end
				S_POW: begin
					if (cnt_q == '0) begin
						den_q       <= mode_q ? mb_q : p_q;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL;
					end else begin
						p_q   <= {p_q[dmd_pkg::MAG_W-4:0], 3'b000}
							+ {p_q[dmd_pkg::MAG_W-2:0], 1'b0};
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_MUL: begin
					if (mul_ctl.done) begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_ctl.done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					q_q     <= div_q + (({div_r, 1'b0} >= {1'b0, den_q})
						? 256'd1 : 256'd0);
					p_q     <= 128'd1;
					cnt_q   <= prec_s1_q;
					state_q <= S_LIM;
				end
				S_LIM: begin
					if (cnt_q == '0) begin
						if (q_q >= {{dmd_pkg::MAG_W{1'b0}}, p_q}) begin
							res_next_q <= '{result_upper: '0, result_lower: '0,
								status: dmd_pkg::ST_NULL};
						end else begin
							res_next_q <= '{result_upper: q_low[127:64],
								result_lower: q_low[63:0], status: dmd_pkg::ST_OK};
						end
						state_q <= S_OUT;
					end else begin
						p_q   <= {p_q[dmd_pkg::MAG_W-4:0], 3'b000}
							+ {p_q[dmd_pkg::MAG_W-2:0], 1'b0};
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_OUT: begin
					if (!res_valid_q || !result_stall) begin
						res_valid_q <= 1'b1;
						res_q       <= res_next_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== design/dmd_mul.sv =====
// bit-serial shift-and-add multiplier, 128 x 128 -> 256 bits
module dmd_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dmd_pkg::MAG_W-1:0]   x,
	input  logic [dmd_pkg::MAG_W-1:0]   y,
	output logic                        done,
	output logic [dmd_pkg::PROD_W-1:0]  prod
);

	logic [dmd_pkg::PROD_W-1:0] prod_q;
	logic [dmd_pkg::MAG_W-1:0]  x_q;
	logic [6:0]                 cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [dmd_pkg::MAG_W:0]    sum;

	assign sum = {1'b0, prod_q[dmd_pkg::PROD_W-1:dmd_pkg::MAG_W]}
		+ (prod_q[0] ? {1'b0, x_q} : {(dmd_pkg::MAG_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 7'd127) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= {{dmd_pkg::MAG_W{1'b0}}, y};
			x_q    <= x;
		end else if (run_q) begin
			prod_q <= {sum, prod_q[dmd_pkg::MAG_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ===== design/dmd_div.sv =====
// bit-serial restoring divider, 256 / 128 bits, one quotient bit a cycle
module dmd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dmd_pkg::PROD_W-1:0]  n,
	input  logic [dmd_pkg::MAG_W-1:0]   d,
	output logic                        done,
	output logic [dmd_pkg::PROD_W-1:0]  q,
	output logic [dmd_pkg::MAG_W-1:0]   r
);

	logic [dmd_pkg::PROD_W-1:0] nq_q;
	logic [dmd_pkg::MAG_W-1:0]  r_q;
	logic [dmd_pkg::MAG_W-1:0]  d_q;
	logic [7:0]                 cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [dmd_pkg::MAG_W:0]    sh;
	logic [dmd_pkg::MAG_W:0]    diff;
	logic                       ge;

	assign sh   = {r_q, nq_q[dmd_pkg::PROD_W-1]};
	assign diff = sh - {1'b0, d_q};
	assign ge   = (sh >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 8'd255) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= n;
			r_q  <= '0;
			d_q  <= d;
		end else if (run_q) begin
			nq_q <= {nq_q[dmd_pkg::PROD_W-2:0], ge};
			r_q  <= ge ? diff[dmd_pkg::MAG_W-1:0] : sh[dmd_pkg::MAG_W-1:0];
		end
	end

	assign done = done_q;
	assign q    = nq_q;
	assign r    = r_q;

endmodule

// ===== design/dmd_div5.sv =====
// digit-serial divide by five, one hex digit a cycle
module dmd_div5 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dmd_pkg::MAG_W-1:0]  c,
	output logic                       done,
	output logic                       exact,
	output logic [dmd_pkg::MAG_W-1:0]  quot
);

	localparam int unsigned DIGITS = dmd_pkg::MAG_W / 4;

	logic [dmd_pkg::MAG_W-1:0] c_q;
	logic [2:0]                rem_q;
	logic [4:0]                cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [6:0]                t;
	logic [3:0]                qd;
	logic [2:0]                rd;

	function automatic logic [6:0] div5_step(input logic [6:0] v);
		logic [6:0] rr;
		logic [3:0] qq;
		rr = v;
		qq = '0;
		for (int b = 3; b >= 0; b--) begin
			if (rr >= 7'(5 << b)) begin
				rr    = rr - 7'(5 << b);
				qq[b] = 1'b1;
			end
		end
		return {qq, rr[2:0]};
	endfunction

	assign t = {rem_q, c_q[dmd_pkg::MAG_W-1 -: 4]};
	assign {qd, rd} = div5_step(t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 5'(DIGITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c_q   <= c;
			rem_q <= '0;
		end else if (run_q) begin
			c_q   <= {c_q[dmd_pkg::MAG_W-5:0], qd};
			rem_q <= rd;
		end
	end

	assign done  = done_q;
	assign exact = (rem_q == 3'd0);
	assign quot  = c_q;

endmodule

// ===== design/dmd_checker.sv =====
// port-level checks of the decimal multiply/divide unit and their binding
module dmd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              operand_valid,
	input logic              operand_stall,
	input logic              result_valid,
	input logic              result_stall,
	input dmd_pkg::result_t  result,
	input logic              cfg_ready
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != dmd_pkg::ST_OK
		|-> result.result_upper == '0 && result.result_lower == '0)
		else $error("non-ok result carries a value");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		operand_valid && !operand_stall |=> operand_stall)
		else $error("input not stalled after transfer");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		operand_valid && !operand_stall |=> !$rose(result_valid))
		else $error("result appeared one cycle after transfer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind decimal_multiply_divide_half_up dmd_checker u_dmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.operand_valid (operand_valid),
	.operand_stall (operand_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.result        (result),
	.cfg_ready     (cfg_ready)
);

// ===== test/decimal_multiply_divide_half_up_tb.sv =====
// testbench of the decimal multiply/divide unit: directed table and random transfers checked by a predictor
module decimal_multiply_divide_half_up_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAXP = 38;
	localparam longint unsigned CYCLE_LIMIT = 64'd20000000;

	typedef struct {
		dmd_pkg::operand_t op;
		bit                has_exp;
		dmd_pkg::result_t  exp;
	} vec_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      operand_valid = 1'b0;
	logic      operand_stall;
	dmd_pkg::operand_t  operand = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	dmd_pkg::result_t   result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	dmd_pkg::cfg_idx_t  cfg_index = dmd_pkg::CFG_PRECISION;
	logic [5:0] cfg_data = '0;

	logic [5:0] precision_q = dmd_pkg::PRECISION_RST;
	logic [5:0] scale_q = dmd_pkg::SCALE_RST;
	dmd_pkg::result_t expected_q[$];
	int         mismatches = 0;
	longint unsigned cycles = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	vec_t       table_q[$];

	decimal_multiply_divide_half_up dut (
		.clk, .arst_n, .operand_valid, .operand_stall, .operand, .result_valid,
		.result_stall, .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [255:0] pow10(int unsigned n);
		logic [255:0] p;
		p = 256'd1;
		for (int i = 0; i < n; i++)
			p = p * 256'd10;
		return p;
	endfunction

	function automatic dmd_pkg::result_t predict_quotient(dmd_pkg::operand_t op);
		int unsigned prec, sc;
		logic sa, sb, neg;
		logic [255:0] ma, mb, num, den, q, r, c;
		dmd_pkg::result_t res;
		prec = (precision_q > MAXP) ? MAXP : precision_q;
		sc = (scale_q > prec) ? prec : scale_q;
		sa = op.left_upper[63];
		sb = op.right_upper[63];
		neg = sa ^ sb;
		ma = {{128{sa}}, op.left_upper, op.left_lower};
		mb = {{128{sb}}, op.right_upper, op.right_lower};
		if (sa) ma = -ma;
		if (sb) mb = -mb;
		res = '0;
		if (!op.mode) begin
			num = ma * mb;
			den = pow10(sc);
		end else begin
			if (mb == 0) begin
				res.status = dmd_pkg::ST_DIVZERO;
				return res;
			end
			c = mb;
			while (c[0] == 1'b0)
				c = c >> 1;
			while (c % 5 == 0)
				c = c / 5;
			if (ma % c != 0) begin
				res.status = dmd_pkg::ST_NONTERM;
				return res;
			end
			num = ma * pow10(sc);
			den = mb;
		end
		q = num / den;
		r = num % den;
		if ((r << 1) >= den)
			q = q + 1;
		if (q >= pow10(prec)) begin
			res.status = dmd_pkg::ST_NULL;
		end else begin
			if (neg) q = -q;
			res.result_upper = q[127:64];
			res.result_lower = q[63:0];
			res.status = dmd_pkg::ST_OK;
		end
		return res;
	endfunction

	// result checker and random receiver stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				if (result.result_upper !== expected_q[0].result_upper ||
				    result.result_lower !== expected_q[0].result_lower ||
				    result.status !== expected_q[0].status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %0d, got %h %h %0d",
							expected_q[0].result_upper, expected_q[0].result_lower,
							expected_q[0].status, result.result_upper,
							result.result_lower, result.status);
				end
				void'(expected_q.pop_front());
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(dmd_pkg::cfg_idx_t idx, logic [5:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == dmd_pkg::CFG_PRECISION) precision_q = value;
		else scale_q = value;
		@(posedge clk);
	endtask

	task automatic drain_and_settle();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// one transfer; checked rows override the predictor and are also compared with it
	task automatic send_operand(dmd_pkg::operand_t op, bit has_exp, dmd_pkg::result_t exp);
		dmd_pkg::result_t p;
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		p = predict_quotient(op);
		if (has_exp && p !== exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with predictor: %h vs %h", exp, p);
		end
		operand_valid <= 1'b1;
		operand <= op;
		do @(posedge clk); while (operand_stall);
		expected_q.push_back(has_exp ? exp : p);
		operand_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [127:0] rand_mag(int unsigned digits);
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		if (digits < 38)
			v = 128'({128'd0, v} % pow10(digits));
		return v;
	endfunction

	function automatic dmd_pkg::operand_t make_op(bit mode, logic [127:0] a, logic [127:0] b);
		dmd_pkg::operand_t op;
		op.mode = mode;
		{op.left_upper, op.left_lower} = a;
		{op.right_upper, op.right_lower} = b;
		return op;
	endfunction

	function automatic dmd_pkg::result_t mk_res(logic [127:0] v, dmd_pkg::status_t s);
		dmd_pkg::result_t r;
		{r.result_upper, r.result_lower} = v;
		r.status = s;
		return r;
	endfunction

	task automatic random_phase(int n);
		dmd_pkg::operand_t op;
		logic [127:0] a, b;
		int unsigned da, db;
		for (int i = 0; i < n; i++) begin
			da = $urandom_range(38);
			db = $urandom_range(38);
			a = rand_mag(da);
			b = rand_mag(db);
			case ($urandom_range(9))
				0: b = 128'(pow10($urandom_range(6)) << $urandom_range(8));
				1: b = 128'd0;
				2: a = b * rand_mag(3);
				3: begin
					a = {$urandom, $urandom, $urandom, $urandom};
					b = {$urandom, $urandom, $urandom, $urandom};
				end
				default: ;
			endcase
			if ($urandom_range(1)) a = -a;
			if ($urandom_range(1)) b = -b;
			op = make_op(1'($urandom_range(1)), a, b);
			send_operand(op, 1'b0, '0);
		end
	endtask

	initial begin
		logic [127:0] big;
		big = (128'd1 << 127) - 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: precision 38, scale 0
		table_q.push_back('{make_op(1'b0, 128'd6, 128'd7), 1'b1,
			mk_res(128'd42, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b0, -128'd6, 128'd7), 1'b1,
			mk_res(-128'd42, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b1, 128'd5, 128'd0), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_DIVZERO)});
		table_q.push_back('{make_op(1'b1, 128'd1, 128'd3), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_NONTERM)});
		table_q.push_back('{make_op(1'b1, 128'd1, 128'd2), 1'b1,
			mk_res(128'd1, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b1, -128'd1, 128'd4), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b1, -128'd2, 128'd4), 1'b1,
			mk_res(-128'd1, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b0, big, big), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_NULL)});
		table_q.push_back('{make_op(1'b0, 128'd1 << 127, 128'd1 << 127), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_NULL)});
		table_q.push_back('{make_op(1'b1, big, 128'd1 << 127), 1'b0, '0});
		table_q.push_back('{make_op(1'b1, 128'd1 << 127, -128'd1), 1'b0, '0});
		table_q.push_back('{make_op(1'b0, 128'd0, big), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b1, 128'd0, 128'd7), 1'b1,
			mk_res(128'd0, dmd_pkg::ST_OK)});
		table_q.push_back('{make_op(1'b0, 128'(pow10(37)), 128'd9), 1'b1,
			mk_res(128'(pow10(37) * 256'd9), dmd_pkg::ST_OK)});
		foreach (table_q[i])
			send_operand(table_q[i].op, table_q[i].has_exp, table_q[i].exp);
		drain_and_settle();

		// scale 2, then precision 0 and out-of-range settings
		write_reg(dmd_pkg::CFG_SCALE, 6'd2);
		send_operand(make_op(1'b0, 128'd150, 128'd101), 1'b0, '0);
		send_operand(make_op(1'b0, -128'd150, 128'd101), 1'b0, '0);
		send_operand(make_op(1'b1, 128'd100, 128'd300), 1'b0, '0);
		send_operand(make_op(1'b1, 128'd1, 128'd8), 1'b0, '0);
		drain_and_settle();
		write_reg(dmd_pkg::CFG_PRECISION, 6'd0);
		send_operand(make_op(1'b0, 128'd0, 128'd5), 1'b0, '0);
		send_operand(make_op(1'b0, 128'd1, 128'd1), 1'b0, '0);
		drain_and_settle();
		write_reg(dmd_pkg::CFG_PRECISION, 6'd63);
		write_reg(dmd_pkg::CFG_SCALE, 6'd63);
		send_operand(make_op(1'b0, 128'(pow10(38) - 256'd1), 128'd1), 1'b0, '0);
		send_operand(make_op(1'b1, 128'(pow10(20)), 128'd1), 1'b0, '0);
		drain_and_settle();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(dmd_pkg::CFG_PRECISION, (ph == 0) ? 6'd1 : 6'($urandom_range(63)));
			write_reg(dmd_pkg::CFG_SCALE, (ph == 1) ? 6'd38 : 6'($urandom_range(12)));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			random_phase(60);
			// hold off until every result is back
			while (expected_q.size() != 0) @(posedge clk);
			random_phase(60);
			drain_and_settle();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_and_settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== decimal_multiply_divide_half_up.f =====
design/dmd_pkg.sv
design/dmd_mul.sv
design/dmd_div.sv
design/dmd_div5.sv
design/decimal_multiply_divide_half_up.sv
design/dmd_checker.sv
test/decimal_multiply_divide_half_up_tb.sv
